>>> hdl/vec4_alu_assert.svh
// Assertion macros for the vector unit top module.
// Depends on nothing; included inside module bodies.
`ifndef VEC4_ALU_ASSERT_SVH
`define VEC4_ALU_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define V4_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define V4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/v4alu_pkg.sv
// Types, constants and helper functions for the four-lane vector unit.
// Depends on nothing; used by every module.
package v4alu_pkg;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  // Depth of the shared pipeline: square stage, root digits, divide bits.
  localparam int ROOT_STEPS = 32;
  localparam int DIV_BITS   = 32 + FRAC_BITS + 1;
  localparam int NUM_W      = 32 + FRAC_BITS + 1;
  localparam int PIPE_DEPTH = 3 + ROOT_STEPS + DIV_BITS + 2;

  typedef enum logic [3:0] {
    OP_ADDV = 4'd0, OP_SUBV = 4'd1, OP_MULV = 4'd2, OP_DIVV = 4'd3,
    OP_ADDS = 4'd4, OP_SUBS = 4'd5, OP_MULS = 4'd6, OP_DIVS = 4'd7,
    OP_NEG  = 4'd8, OP_LEN  = 4'd9, OP_NORM = 4'd10
  } op_t;

  typedef logic signed [31:0] lane_t;

  typedef struct packed {
    logic [3:0]     op;
    lane_t [3:0]    a;
    lane_t [3:0]    b;
    lane_t          s;
  } item_t;

  typedef struct packed {
    lane_t [3:0]    r;
    logic [30:0]    len;
    logic           div_zero;
  } result_t;

  function automatic lane_t sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic lane_t sat_mag(input logic [63:0] m, input logic neg);
    logic signed [64:0] v;
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input lane_t v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction
endpackage

>>> hdl/v4alu_stream_if.sv
// Valid/ready channel carrying one payload item of a given type.
// Depends on nothing but its type parameter.
interface v4alu_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/vec4_alu.sv
// Four-lane Q16.16 vector unit: lanes, length unit and result merge.
// Depends on v4alu_pkg, v4alu_stream_if, vec4_alu_assert.svh, v4alu_lane and v4alu_len.
// Pipeline depth is PIPE_DEPTH; the front stages, root digits and divide bits add up to it.
// Throughput is one item per cycle; the whole pipe advances when the output is free.
// Reset clears the valid flags of every stage; payload registers are not reset.
module vec4_alu (
  input logic clk,
  input logic rst,
  v4alu_stream_if.sink   in_ch,
  v4alu_stream_if.source out_ch
);
  import v4alu_pkg::*;
  `include "vec4_alu_assert.svh"

  localparam int LAT = PIPE_DEPTH;
  localparam int LEN_AT = 3 + ROOT_STEPS - 1;

  logic en;
  logic [LAT-1:0] vld;
  item_t it;
  assign it = in_ch.data;
  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  logic [30:0] len_c;
  lane_t r [LANES];
  v4alu_len u_len (.clk, .en, .x(it.a[0]), .y(it.a[1]), .z(it.a[2]), .len(len_c));

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    v4alu_lane u_lane (.clk, .en, .op_in(it.op), .a_in(it.a[g]), .b_in(it.b[g]),
                       .s_in(it.s), .den_len(len_c), .r_out(r[g]));
  end

  // Side pipe: opcode, zero flags and length to the merge stage.
  logic [3:0]  op_d  [LAT];
  logic        bz_d  [LAT];
  logic [30:0] len_d [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      op_d[0] <= it.op;
      bz_d[0] <= (it.op == OP_DIVV) ? (it.b[0] == 0 || it.b[1] == 0 ||
                 it.b[2] == 0 || it.b[3] == 0) : (it.s == 0);
      for (int i = 1; i < LAT; i++) begin
        op_d[i] <= op_d[i-1];
        bz_d[i] <= bz_d[i-1];
        len_d[i] <= (i == LEN_AT + 1) ? len_c : len_d[i-1];
      end
      len_d[0] <= '0;
    end
  end

  result_t res;
  logic [3:0] opf;
  logic dz, haslen;
  always_comb begin
    opf = op_d[LAT-1];
    haslen = (opf == OP_LEN) || (opf == OP_NORM);
    dz = ((opf == OP_DIVV || opf == OP_DIVS) && bz_d[LAT-1]) ||
         ((opf == OP_NORM) && len_d[LAT-1] == 0);
    res.len = haslen ? len_d[LAT-1] : '0;
    res.div_zero = dz;
    for (int i = 0; i < LANES; i++)
      res.r[i] = (dz || opf == OP_LEN || opf > OP_NORM) ? '0 : r[i];
  end

  assign out_ch.valid = vld[LAT-1];
  assign out_ch.data  = res;

  `V4_ASSERT_IMPL(a_stall_hold, out_ch.valid && !out_ch.ready, !in_ch.ready, "stall leak")
  `V4_ASSERT_IMPL(a_dz_zero, out_ch.valid && out_ch.data.div_zero,
                  out_ch.data.r[0] == 0 && out_ch.data.r[3] == 0, "dz lanes nonzero")
  `V4_ASSERT_NEXT(a_flow, in_ch.valid && in_ch.ready, vld[0], "item lost")
endmodule

>>> hdl/v4alu_lane.sv
// One lane: elementwise add, subtract, negate, multiply and a pipelined
// restoring divider. Depends on v4alu_pkg.
module v4alu_lane (
  input  logic                 clk,
  input  logic                 en,
  input  logic [3:0]           op_in,
  input  v4alu_pkg::lane_t     a_in,
  input  v4alu_pkg::lane_t     b_in,
  input  v4alu_pkg::lane_t     s_in,
  input  logic [30:0]          den_len,
  output v4alu_pkg::lane_t     r_out
);
  import v4alu_pkg::*;

  localparam int QW = NUM_W;
  localparam int PRE = 1 + ROOT_STEPS;

  // Stage 0: simple ops and product.
  logic [3:0]          op0;
  lane_t               simple0;
  logic signed [63:0]  prod0;
  lane_t               a0, d0;
  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= op_in;
      a0  <= a_in;
      d0  <= (op_in == OP_DIVS) ? s_in : b_in;
      prod0 <= $signed(a_in) * ((op_in == OP_MULS) ? s_in : b_in);
      unique case (op_in)
        OP_ADDV: simple0 <= sat34(34'(a_in) + 34'(b_in));
        OP_SUBV: simple0 <= sat34(34'(a_in) - 34'(b_in));
        OP_ADDS: simple0 <= sat34(34'(a_in) + 34'(s_in));
        OP_SUBS: simple0 <= sat34(34'(a_in) - 34'(s_in));
        OP_NEG:  simple0 <= sat34(-34'(a_in));
        default: simple0 <= '0;
      endcase
    end
  end

  // Stage 1: round the product, or pass the simple result on.
  logic [63:0] pmag;
  lane_t       early1;
  logic        isdiv1;
  assign pmag = prod0[63] ? 64'(-prod0) : 64'(prod0);
  always_ff @(posedge clk) begin
    if (en) begin
      isdiv1 <= (op0 == OP_DIVV) || (op0 == OP_DIVS) || (op0 == OP_NORM);
      if (op0 == OP_MULV || op0 == OP_MULS)
        early1 <= sat_mag((pmag + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS, prod0[63]);
      else
        early1 <= simple0;
    end
  end

  // Delay line until the length is known, carrying a and divisor.
  lane_t       dl_early [PRE];
  logic        dl_div   [PRE];
  lane_t       dl_a     [PRE];
  lane_t       dl_d     [PRE];
  logic [3:0]  dl_op    [PRE];
  logic [3:0]  op1;
  lane_t       a1, d1;
  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op0; a1 <= a0; d1 <= d0;
      dl_early[0] <= early1; dl_div[0] <= isdiv1;
      dl_a[0] <= a1; dl_d[0] <= d1; dl_op[0] <= op1;
      for (int i = 1; i < PRE; i++) begin
        dl_early[i] <= dl_early[i-1]; dl_div[i] <= dl_div[i-1];
        dl_a[i] <= dl_a[i-1]; dl_d[i] <= dl_d[i-1]; dl_op[i] <= dl_op[i-1];
      end
    end
  end

  // Divider setup; den_len arrives aligned with the last delay tap.
  logic [32:0]     den_w;
  logic            neg_w;
  logic [QW-1:0]   num_w;
  assign den_w = (dl_op[PRE-1] == OP_NORM) ? {2'b0, den_len}
                                           : {1'b0, mag32(dl_d[PRE-1])};
  assign neg_w = (dl_op[PRE-1] == OP_NORM) ? dl_a[PRE-1][31]
                                           : (dl_a[PRE-1][31] ^ dl_d[PRE-1][31]);
  // Numerator plus half divisor, so truncating division rounds.
  assign num_w = (QW'(mag32(dl_a[PRE-1])) << FRAC_BITS) + QW'(den_w >> 1);

  logic [QW-1:0]  q_n   [DIV_BITS+1];
  logic [QW:0]    rem_n [DIV_BITS+1];
  logic [32:0]    den_n [DIV_BITS+1];
  logic           neg_n [DIV_BITS+1];
  lane_t          e_n   [DIV_BITS+1];
  logic           v_n   [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      q_n[0] <= num_w; rem_n[0] <= '0; den_n[0] <= den_w;
      neg_n[0] <= neg_w; e_n[0] <= dl_early[PRE-1]; v_n[0] <= dl_div[PRE-1];
      for (int k = 0; k < DIV_BITS; k++) begin
        logic [QW:0] t;
        t = {rem_n[k][QW-1:0], q_n[k][QW-1]};
        if (t >= (QW+1)'(den_n[k])) begin
          rem_n[k+1] <= t - (QW+1)'(den_n[k]);
          q_n[k+1]   <= {q_n[k][QW-2:0], 1'b1};
        end else begin
          rem_n[k+1] <= t;
          q_n[k+1]   <= {q_n[k][QW-2:0], 1'b0};
        end
        den_n[k+1] <= den_n[k]; neg_n[k+1] <= neg_n[k];
        e_n[k+1] <= e_n[k]; v_n[k+1] <= v_n[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_n[DIV_BITS])
        r_out <= sat_mag(64'(q_n[DIV_BITS]), neg_n[DIV_BITS]);
      else
        r_out <= e_n[DIV_BITS];
    end
  end
endmodule

>>> hdl/v4alu_len.sv
// Length unit: sum of three squares and a pipelined digit square root.
// Depends on v4alu_pkg.
module v4alu_len (
  input  logic              clk,
  input  logic              en,
  input  v4alu_pkg::lane_t  x,
  input  v4alu_pkg::lane_t  y,
  input  v4alu_pkg::lane_t  z,
  output logic [30:0]       len
);
  import v4alu_pkg::*;

  logic [63:0] sq [3];
  logic [65:0] sum;
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= mag32(x) * mag32(x);
      sq[1] <= mag32(y) * mag32(y);
      sq[2] <= mag32(z) * mag32(z);
      sum   <= 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
    end
  end

  // Bit-pair restoring root, one result bit per stage (33 bits for 66-bit sum).
  localparam int RB = 33;

  logic [65:0] vs [ROOT_STEPS];
  logic [67:0] rs [ROOT_STEPS+1];
  logic [RB-1:0] qs [ROOT_STEPS+1];
  logic [67:0] rem1;
  logic [RB-1:0] q1;
  // First digit combinational from the registered sum, rest pipelined.
  always_comb begin
    logic [67:0] t, trial;
    t = {66'b0, sum[65:64]};
    trial = 68'd1;
    if (t >= trial) begin rem1 = t - trial; q1 = RB'(1); end
    else begin rem1 = t; q1 = '0; end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      vs[0] <= sum << 2; rs[0] <= rem1; qs[0] <= q1;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        logic [67:0] t, trial;
        t = {rs[k][65:0], vs[k][65:64]};
        trial = {33'b0, qs[k], 2'b01};
        if (t >= trial) begin
          rs[k+1] <= t - trial; qs[k+1] <= {qs[k][RB-2:0], 1'b1};
        end else begin
          rs[k+1] <= t; qs[k+1] <= {qs[k][RB-2:0], 1'b0};
        end
      end
      for (int k = 1; k < ROOT_STEPS; k++)
        vs[k] <= vs[k-1] << 2;
    end
  end

  logic [RB:0] rounded;
  assign rounded = (68'(rs[ROOT_STEPS]) > 68'(qs[ROOT_STEPS])) ?
                   {1'b0, qs[ROOT_STEPS]} + 1'b1 : {1'b0, qs[ROOT_STEPS]};
  assign len = (rounded > 34'd2147483647) ? 31'h7fffffff : rounded[30:0];
endmodule
